// ===== rtl/contact_table_with_eviction_assert.svh =====
// Assertion macros for the contact table block.
// Used by the top level; expects clk and arst_n in scope.
`ifndef CONTACT_TABLE_WITH_EVICTION_ASSERT_SVH
`define CONTACT_TABLE_WITH_EVICTION_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CTE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define CTE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/cte_pkg.sv =====
// Shared types and constants of the contact table block.
// No dependencies.
package cte_pkg;

	localparam int MAC_W  = 48;
	localparam int TIME_W = 32;
	localparam int LVL_W  = 2;
	localparam int OP_W   = 2;
	localparam int STAT_W = 2;
	localparam int SLOT_W = 6;
	localparam int CNT_W  = 6;

	localparam logic [TIME_W-1:0] STALE_RESET = 32'd900000;

	localparam logic [OP_W-1:0] OP_SIGHT = 2'd0;
	localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

	localparam logic [STAT_W-1:0] STAT_MATCH = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NEW   = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EVICT = 2'd2;
	localparam logic [STAT_W-1:0] STAT_OTHER = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIN
	} cte_state_t;

	typedef struct packed {
		logic              valid;
		logic [MAC_W-1:0]  mac;
		logic [LVL_W-1:0]  level;
		logic [TIME_W-1:0] seen;
	} cte_entry_t;

	typedef struct packed {
		logic shift;
		logic clear;
	} cte_ctl_t;

	typedef struct packed {
		logic             hit;
		logic             free;
		logic [LVL_W-1:0] hit_level;
		logic [CNT_W-1:0] count;
		logic [LVL_W-1:0] top;
	} cte_scan_t;

endpackage

// ===== rtl/cte_cell.sv =====
// One table cell of the contact ring: holds an entry and passes it to its neighbor.
// Depends on cte_pkg.
module cte_cell import cte_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cte_ctl_t   ctl,
	input  logic       wr_en,
	input  cte_entry_t wr_data,
	input  cte_entry_t nbr,
	output cte_entry_t ent
);

	logic              valid_q;
	logic [MAC_W-1:0]  mac_q;
	logic [LVL_W-1:0]  level_q;
	logic [TIME_W-1:0] seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clear) begin
			valid_q <= 1'b0;
		end else if (wr_en) begin
			valid_q <= 1'b1;
		end else if (ctl.shift) begin
			valid_q <= nbr.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mac_q   <= wr_data.mac;
			level_q <= wr_data.level;
			seen_q  <= wr_data.seen;
		end else if (ctl.shift) begin
			mac_q   <= nbr.mac;
			level_q <= nbr.level;
			seen_q  <= nbr.seen;
		end
	end

	assign ent = '{valid: valid_q, mac: mac_q, level: level_q, seen: seen_q};

endmodule

// ===== rtl/cte_scan.sv =====
// Scan unit at the head of the ring: finds match, first free slot and victim,
// and counts active entries of nonzero level and finds the top active level. Depends on cte_pkg.
module cte_scan import cte_pkg::*; #(
	parameter int CONTACTS = 48
) (
	input  logic                        clk,
	input  logic                        step,
	input  logic                        first,
	input  logic [$clog2(CONTACTS)-1:0] idx,
	input  cte_entry_t                  head,
	input  logic [MAC_W-1:0]            mac,
	input  logic [TIME_W-1:0]           now_ms,
	input  logic [TIME_W-1:0]           window,
	output cte_scan_t                   res,
	output logic [$clog2(CONTACTS)-1:0] hit_idx,
	output logic [$clog2(CONTACTS)-1:0] empty_idx,
	output logic [$clog2(CONTACTS)-1:0] vic_idx
);

	localparam int IW = $clog2(CONTACTS);

	logic              hit_q, free_q;
	logic [LVL_W-1:0]  hit_level_q, top_q, vic_level_q;
	logic [CNT_W-1:0]  count_q;
	logic [IW-1:0]     hit_idx_q, empty_idx_q, vic_idx_q;
	logic [TIME_W-1:0] vic_seen_q;

	logic              hit_d, free_d, active, older;
	logic [LVL_W-1:0]  hit_level_d, top_d, vic_level_d;
	logic [CNT_W-1:0]  count_d;
	logic [IW-1:0]     hit_idx_d, empty_idx_d, vic_idx_d;
	logic [TIME_W-1:0] vic_seen_d, age;

	always_comb begin
		hit_d       = first ? 1'b0 : hit_q;
		hit_idx_d   = hit_idx_q;
		hit_level_d = hit_level_q;
		free_d      = first ? 1'b0 : free_q;
		empty_idx_d = empty_idx_q;
		count_d     = first ? '0 : count_q;
		top_d       = first ? '0 : top_q;
		vic_idx_d   = vic_idx_q;
		vic_level_d = vic_level_q;
		vic_seen_d  = vic_seen_q;
		age         = now_ms - head.seen;
		active      = head.valid && (age < window);
		older       = (head.level < vic_level_q) ||
		              ((head.level == vic_level_q) && (head.seen < vic_seen_q));
		if (head.valid) begin
			if (!hit_d && head.mac == mac) begin
				hit_d       = 1'b1;
				hit_idx_d   = idx;
				hit_level_d = head.level;
			end
		end else if (!free_d) begin
			free_d      = 1'b1;
			empty_idx_d = idx;
		end
		if (active) begin
			if (head.level != '0) begin
				count_d = count_d + CNT_W'(1);
			end
			if (head.level > top_d) begin
				top_d = head.level;
			end
		end
		if (first || older) begin
			vic_idx_d   = idx;
			vic_level_d = head.level;
			vic_seen_d  = head.seen;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			hit_q       <= hit_d;
			hit_idx_q   <= hit_idx_d;
			hit_level_q <= hit_level_d;
			free_q      <= free_d;
			empty_idx_q <= empty_idx_d;
			count_q     <= count_d;
			top_q       <= top_d;
			vic_idx_q   <= vic_idx_d;
			vic_level_q <= vic_level_d;
			vic_seen_q  <= vic_seen_d;
		end
	end

	assign res = '{hit: hit_q, free: free_q, hit_level: hit_level_q,
	               count: count_q, top: top_q};
	assign hit_idx   = hit_idx_q;
	assign empty_idx = empty_idx_q;
	assign vic_idx   = vic_idx_q;

endmodule

// ===== rtl/contact_table_with_eviction.sv =====
// Top level of the contact table: request control, cell ring, scan unit, result register.
// Depends on cte_pkg, cte_cell, cte_scan and contact_table_with_eviction_assert.svh.
//
// A table of CONTACTS device entries keyed by 48-bit MAC, held in a ring of cells
// that rotates past a scan unit at its head. One request is in progress at a time.
// A sighting or query makes one full rotation of the ring, one entry through the
// scan unit per cycle, and then a finish step that, for a sighting, writes the
// chosen cell, and loads the result register; a clear or an unused code goes
// straight to the finish step. The finish step waits while an earlier result is
// still stalled in the result register. A new request is taken in the cycle after
// the previous one has moved into the result register, even while that result is
// still stalled.
// Reset and clear empty the table at once.
`include "contact_table_with_eviction_assert.svh"
module contact_table_with_eviction import cte_pkg::*; #(
	parameter int CONTACTS = 48
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wen,
	input  logic [TIME_W-1:0] cfg_wdata,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [OP_W-1:0]   operation,
	input  logic [MAC_W-1:0]  mac,
	input  logic [TIME_W-1:0] now_ms,
	input  logic [LVL_W-1:0]  level_in,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [SLOT_W-1:0] slot,
	output logic [STAT_W-1:0] status,
	output logic [LVL_W-1:0]  level_now,
	output logic [CNT_W-1:0]  active_count,
	output logic [LVL_W-1:0]  top_level
);

	localparam int IW = $clog2(CONTACTS);

	cte_state_t        state_q, state_d;
	logic [IW-1:0]     cnt_q, cnt_d;
	logic [TIME_W-1:0] stale_q;
	logic [OP_W-1:0]   op_q;
	logic [MAC_W-1:0]  mac_q;
	logic [TIME_W-1:0] now_q;
	logic [LVL_W-1:0]  lvl_q;

	logic              accept, out_free, fin_go, wr_go, scan_step, last;
	cte_ctl_t          ctl;
	cte_entry_t        ents [CONTACTS];
	cte_entry_t        wr_data;
	cte_scan_t         res;
	logic [IW-1:0]     hit_idx, empty_idx, vic_idx, widx;
	logic [LVL_W-1:0]  new_level;
	logic [STAT_W-1:0] sight_stat;

	logic              out_valid_q;
	logic [SLOT_W-1:0] slot_q;
	logic [STAT_W-1:0] status_q;
	logic [LVL_W-1:0]  level_now_q, top_q;
	logic [CNT_W-1:0]  count_q;

	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign last     = (cnt_q == IW'(CONTACTS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stale_q <= STALE_RESET;
		end else if (cfg_wen) begin
			stale_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= operation;
			mac_q <= mac;
			now_q <= now_ms;
			lvl_q <= level_in;
		end
	end

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		in_stall  = 1'b1;
		scan_step = 1'b0;
		fin_go    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (operation inside {OP_SIGHT, OP_QUERY}) begin
						state_d = ST_SCAN;
					end else begin
						state_d = ST_FIN;
					end
				end
			end
			ST_SCAN: begin
				scan_step = 1'b1;
				if (last) begin
					cnt_d   = '0;
					state_d = ST_FIN;
				end else begin
					cnt_d = cnt_q + IW'(1);
				end
			end
			ST_FIN: begin
				if (out_free) begin
					fin_go  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
				cnt_d   = '0;
			end
		endcase
	end

	assign ctl.shift = scan_step;
	assign ctl.clear = fin_go && (op_q == OP_CLEAR);
	assign wr_go     = fin_go && (op_q == OP_SIGHT);

	assign widx      = res.hit ? hit_idx : (res.free ? empty_idx : vic_idx);
	assign new_level = (res.hit && res.hit_level > lvl_q) ? res.hit_level : lvl_q;
	assign sight_stat = res.hit ? STAT_MATCH : (res.free ? STAT_NEW : STAT_EVICT);
	assign wr_data   = '{valid: 1'b1, mac: mac_q, level: new_level, seen: now_q};

	for (genvar k = 0; k < CONTACTS; k++) begin : g_ring
		cte_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.wr_en   (wr_go && (widx == IW'(k))),
			.wr_data (wr_data),
			.nbr     (ents[(k + 1) % CONTACTS]),
			.ent     (ents[k])
		);
	end

	cte_scan #(
		.CONTACTS (CONTACTS)
	) u_scan (
		.clk       (clk),
		.step      (scan_step),
		.first     (cnt_q == '0),
		.idx       (cnt_q),
		.head      (ents[0]),
		.mac       (mac_q),
		.now_ms    (now_q),
		.window    (stale_q),
		.res       (res),
		.hit_idx   (hit_idx),
		.empty_idx (empty_idx),
		.vic_idx   (vic_idx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			slot_q      <= '0;
			status_q    <= STAT_OTHER;
			level_now_q <= '0;
			count_q     <= '0;
			top_q       <= '0;
			if (op_q == OP_SIGHT) begin
				slot_q      <= SLOT_W'(widx);
				status_q    <= sight_stat;
				level_now_q <= new_level;
			end else if (op_q == OP_QUERY) begin
				count_q <= res.count;
				top_q   <= res.top;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign slot         = slot_q;
	assign status       = status_q;
	assign level_now    = level_now_q;
	assign active_count = count_q;
	assign top_level    = top_q;

	`CTE_ASSERT_NXT(a_accept_busy, accept, state_q != ST_IDLE, "request accepted but block idle")
	`CTE_ASSERT_NXT(a_scan_runs, (state_q == ST_SCAN) && !last, state_q == ST_SCAN,
		"scan left before full rotation")
	`CTE_ASSERT_IMP(a_write_origin, wr_go, cnt_q == '0, "cell write with ring off origin")
	`CTE_ASSERT_NXT(a_fin_holds, (state_q == ST_FIN) && !out_free,
		(state_q == ST_FIN) && $stable(op_q), "finish lost while result stalled")

endmodule

// ===== bench/contact_table_checker.sv =====
// Checker for the contact table: watches both channels, predicts each result and compares.
// Depends on cte_pkg; instantiated beside the block by contact_table_with_eviction_tb.
module contact_table_checker import cte_pkg::*; #(
	parameter int CONTACTS = 48
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wen,
	input  logic [TIME_W-1:0] cfg_wdata,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [OP_W-1:0]   operation,
	input  logic [MAC_W-1:0]  mac,
	input  logic [TIME_W-1:0] now_ms,
	input  logic [LVL_W-1:0]  level_in,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [SLOT_W-1:0] slot,
	input  logic [STAT_W-1:0] status,
	input  logic [LVL_W-1:0]  level_now,
	input  logic [CNT_W-1:0]  active_count,
	input  logic [LVL_W-1:0]  top_level,
	output int                fail_count,
	output int                pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic [STAT_W-1:0] status;
		logic [LVL_W-1:0]  level_now;
		logic [CNT_W-1:0]  active_count;
		logic [LVL_W-1:0]  top_level;
	} contact_outcome_t;

	logic              known_valid [CONTACTS];
	logic [MAC_W-1:0]  known_mac [CONTACTS];
	logic [LVL_W-1:0]  known_level [CONTACTS];
	logic [TIME_W-1:0] last_seen [CONTACTS];
	logic [TIME_W-1:0] stale_window;

	contact_outcome_t awaited_outcomes [$];
	contact_outcome_t want;

	initial begin
		fail_count = 0;
		pending = 0;
	end

	function automatic void wipe_table();
		for (int i = 0; i < CONTACTS; i++) begin
			known_valid[i] = 1'b0;
			known_mac[i] = '0;
			known_level[i] = '0;
			last_seen[i] = '0;
		end
	endfunction

	function automatic contact_outcome_t predict_contact(
		input logic [OP_W-1:0]   op,
		input logic [MAC_W-1:0]  m,
		input logic [TIME_W-1:0] t,
		input logic [LVL_W-1:0]  lvl
	);
		contact_outcome_t r;
		int hit;
		int vacant;
		int idx;
		logic [TIME_W-1:0] age;
		r = '0;
		r.status = STAT_OTHER;
		case (op)
			OP_SIGHT: begin
				hit = -1;
				vacant = -1;
				for (int i = 0; i < CONTACTS; i++) begin
					if (known_valid[i]) begin
						if (hit < 0 && known_mac[i] == m)
							hit = i;
					end else if (vacant < 0) begin
						vacant = i;
					end
				end
				if (hit >= 0) begin
					idx = hit;
					r.status = STAT_MATCH;
				end else begin
					if (vacant >= 0) begin
						idx = vacant;
						r.status = STAT_NEW;
					end else begin
						idx = 0;
						for (int i = 1; i < CONTACTS; i++) begin
							if (known_level[i] < known_level[idx] ||
							    (known_level[i] == known_level[idx] &&
							     last_seen[i] < last_seen[idx]))
								idx = i;
						end
						r.status = STAT_EVICT;
					end
					known_valid[idx] = 1'b1;
					known_mac[idx] = m;
					known_level[idx] = '0;
				end
				last_seen[idx] = t;
				if (lvl > known_level[idx])
					known_level[idx] = lvl;
				r.slot = SLOT_W'(idx);
				r.level_now = known_level[idx];
			end
			OP_QUERY: begin
				for (int i = 0; i < CONTACTS; i++) begin
					age = t - last_seen[i];
					if (known_valid[i] && age < stale_window) begin
						if (known_level[i] != '0)
							r.active_count = r.active_count + 1'b1;
						if (known_level[i] > r.top_level)
							r.top_level = known_level[i];
					end
				end
			end
			OP_CLEAR: wipe_table();
			default: ;
		endcase
		return r;
	endfunction

	task automatic check_field(input string name, input int expected, input int actual);
		if (expected != actual) begin
			if (fail_count < 10)
				$display("%0t mismatch on %s: expected %0d, got %0d",
				         $realtime, name, expected, actual);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wipe_table();
			stale_window = STALE_RESET;
			awaited_outcomes.delete();
			pending = 0;
		end else begin
			if (cfg_wen)
				stale_window = cfg_wdata;
			if (in_valid && !in_stall)
				awaited_outcomes.push_back(predict_contact(operation, mac, now_ms, level_in));
			if (out_valid && !out_stall) begin
				if (awaited_outcomes.size() == 0) begin
					if (fail_count < 10)
						$display("%0t result with no request waiting: slot %0d status %0d",
						         $realtime, slot, status);
					fail_count++;
				end else begin
					want = awaited_outcomes.pop_front();
					check_field("slot", want.slot, slot);
					check_field("status", want.status, status);
					check_field("level_now", want.level_now, level_now);
					check_field("active_count", want.active_count, active_count);
					check_field("top_level", want.top_level, top_level);
				end
			end
			pending = awaited_outcomes.size();
		end
	end

endmodule

// ===== bench/contact_table_with_eviction_tb.sv =====
// Top of the contact table bench: clock, reset, request and stall stimulus, verdict.
// Depends on cte_pkg, contact_table_with_eviction and contact_table_checker.
module contact_table_with_eviction_tb;
	import cte_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CONTACTS = 48;
	localparam int MAC_POOL = 64;
	localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

	logic              clk;
	logic              arst_n;
	logic              cfg_wen;
	logic [TIME_W-1:0] cfg_wdata;
	logic              in_valid;
	logic              in_stall;
	logic [OP_W-1:0]   operation;
	logic [MAC_W-1:0]  mac;
	logic [TIME_W-1:0] now_ms;
	logic [LVL_W-1:0]  level_in;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [SLOT_W-1:0] slot;
	logic [STAT_W-1:0] status;
	logic [LVL_W-1:0]  level_now;
	logic [CNT_W-1:0]  active_count;
	logic [LVL_W-1:0]  top_level;

	int fail_count;
	int pending;

	logic tx_calm = 1'b0;
	logic rx_calm = 1'b0;
	logic hold_go = 1'b0;
	logic hold_off = 1'b0;

	logic [MAC_W-1:0]  mac_pool [MAC_POOL];
	logic [TIME_W-1:0] clock_ms;

	contact_table_with_eviction #(.CONTACTS(CONTACTS)) u_top (
		.clk(clk), .arst_n(arst_n), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .operation(operation), .mac(mac),
		.now_ms(now_ms), .level_in(level_in), .out_valid(out_valid), .out_stall(out_stall),
		.slot(slot), .status(status), .level_now(level_now),
		.active_count(active_count), .top_level(top_level)
	);

	contact_table_checker #(.CONTACTS(CONTACTS)) u_check (
		.clk(clk), .arst_n(arst_n), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .operation(operation), .mac(mac),
		.now_ms(now_ms), .level_in(level_in), .out_valid(out_valid), .out_stall(out_stall),
		.slot(slot), .status(status), .level_now(level_now),
		.active_count(active_count), .top_level(top_level),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

	always @(posedge clk)
		out_stall <= hold_off || (!rx_calm && $urandom_range(99) < 19);

	// hold the receiver off long enough to back the block up
	initial begin
		@(posedge hold_go);
		hold_off <= 1'b1;
		repeat (400) @(posedge clk);
		hold_off <= 1'b0;
	end

	task automatic offer(
		input logic [OP_W-1:0]   op,
		input logic [MAC_W-1:0]  m,
		input logic [TIME_W-1:0] t,
		input logic [LVL_W-1:0]  lvl
	);
		if (!tx_calm && $urandom_range(99) < 19) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 60)) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		mac <= m;
		now_ms <= t;
		level_in <= lvl;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		@(posedge clk);
	endtask

	task automatic set_window(input logic [TIME_W-1:0] value);
		cfg_wen <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic random_request(input int unsigned step);
		int unsigned pick;
		logic [MAC_W-1:0] m;
		logic [TIME_W-1:0] t;
		pick = $urandom_range(99);
		clock_ms = clock_ms + $urandom_range(0, step);
		t = ($urandom_range(99) < 10) ? $urandom() : clock_ms;
		if ($urandom_range(99) < 85)
			m = mac_pool[$urandom_range(MAC_POOL - 1)];
		else
			m = {16'($urandom()), 32'($urandom())};
		if (pick < 75)
			offer(OP_SIGHT, m, t, LVL_W'($urandom_range(3)));
		else if (pick < 96)
			offer(OP_QUERY, m, t, LVL_W'($urandom_range(3)));
		else if (pick < 98)
			offer(OP_SPARE, m, t, LVL_W'($urandom_range(3)));
		else
			offer(OP_CLEAR, m, t, LVL_W'($urandom_range(3)));
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		operation = OP_SIGHT;
		mac = '0;
		now_ms = '0;
		level_in = '0;
		clock_ms = $urandom();
		for (int i = 0; i < MAC_POOL; i++)
			mac_pool[i] = {16'($urandom()), 32'($urandom())};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		offer(OP_QUERY, '0, '0, '0);
		offer(OP_SIGHT, '0, '0, '0);
		offer(OP_SIGHT, '1, '1, 2'd3);
		offer(OP_SIGHT, '0, 32'd10, 2'd2);
		offer(OP_SIGHT, '0, 32'd20, 2'd1);
		offer(OP_QUERY, '0, 32'd5, '0);
		offer(OP_QUERY, '1, 32'd900019, 2'd3);
		offer(OP_QUERY, '0, 32'd900020, '0);
		offer(OP_SPARE, '1, '1, 2'd3);
		offer(OP_CLEAR, '0, '0, '0);
		offer(OP_QUERY, '0, 32'd100, '0);
		offer(OP_SIGHT, 48'h5555_5555_5555, 32'h5555_5555, 2'd1);
		offer(OP_SIGHT, 48'hAAAA_AAAA_AAAA, 32'hAAAA_AAAA, 2'd2);
		settle();
		set_window('0);
		offer(OP_QUERY, '0, 32'h5555_5555, '0);
		settle();
		set_window(32'd1);
		offer(OP_QUERY, '0, 32'h5555_5555, '0);
		offer(OP_QUERY, '0, 32'h5555_5556, '0);
		settle();
		set_window('1);
		offer(OP_QUERY, '0, 32'h5555_5554, '0);
		offer(OP_QUERY, '0, '0, '0);

		for (int p = 0; p < 5; p++) begin
			int unsigned step;
			settle();
			case (p)
				0: begin set_window(STALE_RESET); step = 60000; end
				1: begin set_window(32'd1); step = 2; hold_go <= 1'b1; end
				2: begin set_window('1); step = 1 << 20; end
				3: begin set_window('0); step = 1000; end
				default: begin
					set_window($urandom_range(1000, 5000000));
					step = 200000;
				end
			endcase
			tx_calm <= (p == 2);
			rx_calm <= (p == 2);
			repeat (90) random_request(step);
		end

		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (CONTACTS + 8) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/cte_pkg.sv
rtl/cte_cell.sv
rtl/cte_scan.sv
rtl/contact_table_with_eviction.sv
bench/contact_table_checker.sv
bench/contact_table_with_eviction_tb.sv
